// ===== design/assert_macros.svh =====
// Assertion shorthands for the tangent/binormal unit.
// Expects clk and rst (synchronous, active high) in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/tbn_pkg.sv =====
// Shared types and constants of the tangent/binormal unit.
// No dependencies.
package tbn_pkg;

  localparam int IN_W      = 32;
  localparam int OUT_W     = 16;
  localparam int SLOPE_W   = 33;
  localparam int MAG_W     = 32;
  localparam int SUM_W     = 64;
  localparam int ROOT_W    = 32;
  localparam int Q_W       = 31;
  localparam int FRAC_SH   = 15;
  localparam int ZPAD_W    = Q_W - FRAC_SH;
  localparam int NS_W      = MAG_W + FRAC_SH + 1;
  localparam int DIV_CNT_W = $clog2(Q_W + 1);

  localparam logic signed [OUT_W-1:0]   ONE_Q14   = 16'sd16384;
  localparam logic signed [SLOPE_W-1:0] SLOPE_SAT = 33'sd2147483648;
  localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = 33'sd2147483647;

  typedef struct packed {
    logic start;
    logic clr;
    logic neg;
  } mac_cmd_t;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_MAC   = 12'b0000_0000_0010,
    ST_MACW  = 12'b0000_0000_0100,
    ST_DIV   = 12'b0000_0000_1000,
    ST_DIVW  = 12'b0000_0001_0000,
    ST_LOAD  = 12'b0000_0010_0000,
    ST_SHIFT = 12'b0000_0100_0000,
    ST_SQRT  = 12'b0000_1000_0000,
    ST_SQRTW = 12'b0001_0000_0000,
    ST_NDIV  = 12'b0010_0000_0000,
    ST_NDIVW = 12'b0100_0000_0000,
    ST_DONE  = 12'b1000_0000_0000
  } state_t;

endpackage

// ===== design/tbn_mac.sv =====
// Bit-serial signed multiply-accumulate, one multiplier bit per cycle.
// Depends on tbn_pkg.
module tbn_mac import tbn_pkg::*; #(
  parameter int OP_W  = 33,
  parameter int ACC_W = 67
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_cmd_t                cmd,
  input  logic signed [OP_W-1:0]  a,
  input  logic signed [OP_W-1:0]  b,
  output logic                    busy,
  output logic                    done,
  output logic signed [ACC_W-1:0] acc
);

  localparam int CNT_W = $clog2(OP_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [ACC_W-1:0] mcand;
  logic [ACC_W-1:0] prod;
  logic [OP_W-1:0]  mb;
  logic [OP_W-1:0]  mag_a;
  logic [OP_W-1:0]  mag_b;
  logic             neg;
  logic             clr;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] term;

  assign mag_a = a[OP_W-1] ? OP_W'(-a) : OP_W'(a);
  assign mag_b = b[OP_W-1] ? OP_W'(-b) : OP_W'(b);
  assign base  = clr ? '0 : acc;
  assign term  = neg ? -$signed(prod) : $signed(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cnt   <= CNT_W'(OP_W);
      mcand <= ACC_W'(mag_a);
      mb    <= mag_b;
      prod  <= '0;
      neg   <= a[OP_W-1] ^ b[OP_W-1] ^ cmd.neg;
      clr   <= cmd.clr;
    end else if (busy) begin
      if (cnt != '0) begin
        if (mb[0]) begin
          prod <= prod + mcand;
        end
        mcand <= mcand << 1;
        mb    <= mb >> 1;
        cnt   <= cnt - 1'b1;
      end else begin
        acc <= base + term;
      end
    end
  end

endmodule

// ===== design/tbn_div.sv =====
// Restoring divider, one quotient bit per cycle from a serial dividend stream.
// Depends on tbn_pkg.
module tbn_div import tbn_pkg::*; #(
  parameter int DEN_W = 67
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DEN_W-1:0]     rem0,
  input  logic [Q_W-1:0]       seq,
  input  logic [DIV_CNT_W-1:0] steps,
  input  logic [DEN_W-1:0]     den,
  output logic                 busy,
  output logic                 done,
  output logic [Q_W-1:0]       quot
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     dreg;
  logic [Q_W-1:0]       sreg;
  logic [DEN_W:0]       trial;
  logic                 ge;

  assign trial = {rem, sreg[Q_W-1]};
  assign ge    = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= steps;
      rem  <= rem0;
      dreg <= den;
      sreg <= seq;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? DEN_W'(trial - {1'b0, dreg}) : DEN_W'(trial);
      quot <= {quot[Q_W-2:0], ge};
      sreg <= sreg << 1;
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

// ===== design/tbn_sqrt.sv =====
// Bitwise integer square root, one root bit per cycle.
// Depends on tbn_pkg.
module tbn_sqrt import tbn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  x,
  output logic              busy,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] xr;
  logic [SUM_W-1:0] r;
  logic [SUM_W-1:0] bitr;
  logic [SUM_W-1:0] trial;

  assign trial = r + bitr;
  assign root  = r[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= CNT_W'(ROOT_W);
      xr   <= x;
      r    <= '0;
      bitr <= SUM_W'(1) << (SUM_W - 2);
    end else if (busy) begin
      if (xr >= trial) begin
        xr <= xr - trial;
        r  <= (r >> 1) + bitr;
      end else begin
        r <= r >> 1;
      end
      bitr <= bitr >> 2;
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

// ===== design/triangle_tangent_binormal_unit.sv =====
// Triangle tangent/binormal unit: takes one vertex per transfer, and after every third
// vertex delivers one unit tangent and binormal (Q1.14) for that triangle. The first two
// vertices of a triangle are only stored. The third starts a sequence on one bit-serial
// multiply-accumulator (20 products: two for the area term, four per axis for the slope
// numerators, three per sum of squares), one serial divider (six slopes, six normalizing
// quotients) and a serial square root (two roots), plus a load step and a shift loop per
// vector. A degenerate triangle ends after the first two products. One finished result waits
// in the output register while the next vertices come in.
`include "assert_macros.svh"

module triangle_tangent_binormal_unit import tbn_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [IN_W-1:0]  pos_x,
  input  logic signed [IN_W-1:0]  pos_y,
  input  logic signed [IN_W-1:0]  pos_z,
  input  logic signed [IN_W-1:0]  tex_u,
  input  logic signed [IN_W-1:0]  tex_v,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] tangent_x,
  output logic signed [OUT_W-1:0] tangent_y,
  output logic signed [OUT_W-1:0] tangent_z,
  output logic signed [OUT_W-1:0] binormal_x,
  output logic signed [OUT_W-1:0] binormal_y,
  output logic signed [OUT_W-1:0] binormal_z,
  output logic                    degenerate
);

  localparam int DW    = COORD_WIDTH + 1;
  localparam int PW    = 2 * DW + 1;
  localparam int OP_W  = (DW > SLOPE_W) ? DW : SLOPE_W;
  localparam int ACC_W = (PW > SUM_W + 1) ? PW : SUM_W + 1;
  localparam int DEN_W = PW;

  function automatic logic signed [DW-1:0] sx(input logic [COORD_WIDTH-1:0] x);
    return $signed({x[COORD_WIDTH-1], x});
  endfunction

  state_t state;
  logic [1:0] phase;
  logic [COORD_WIDTH-1:0] sv_px [2];
  logic [COORD_WIDTH-1:0] sv_py [2];
  logic [COORD_WIDTH-1:0] sv_pz [2];
  logic [COORD_WIDTH-1:0] sv_u  [2];
  logic [COORD_WIDTH-1:0] sv_v  [2];

  logic signed [DW-1:0] du1, dv1, du2, dv2;
  logic signed [DW-1:0] dp1 [3];
  logic signed [DW-1:0] dp2 [3];

  logic       cx_ok, in_norm, nv;
  logic [1:0] mi;
  logic [2:0] k;
  logic [1:0] axis;

  logic signed [PW-1:0] cx_reg;
  logic [PW-1:0]        cx_mag;
  logic                 div_sat, div_neg;

  logic signed [SLOPE_W-1:0] tin [3];
  logic signed [SLOPE_W-1:0] bin [3];
  logic [MAG_W-1:0]          m   [3];
  logic [ROOT_W-1:0]         len;

  logic signed [OUT_W-1:0] res_t [3];
  logic signed [OUT_W-1:0] res_b [3];
  logic                    res_deg;

  mac_cmd_t                mac_cmd;
  logic signed [OP_W-1:0]  mac_a, mac_b;
  logic                    mac_busy, mac_done;
  logic signed [ACC_W-1:0] acc;

  logic                 div_start, div_busy, div_done;
  logic [DEN_W-1:0]     div_rem0, div_den;
  logic [Q_W-1:0]       div_seq, div_quot;
  logic [DIV_CNT_W-1:0] div_steps;

  logic              sqrt_busy, sqrt_done;
  logic [ROOT_W-1:0] root;

  logic signed [DW-1:0]      s_dp1, s_dp2;
  logic [MAG_W-1:0]          s_m;
  logic signed [SLOPE_W-1:0] s_vec;
  logic signed [PW-1:0]      num;
  logic [PW-1:0]             num_mag;
  logic [NS_W-1:0]           nsum;
  logic [SLOPE_W-1:0]        qv;
  logic signed [SLOPE_W-1:0] slope, slope_st;
  logic [FRAC_SH-1:0]        qn;
  logic [OUT_W-1:0]          qc;
  logic signed [OUT_W-1:0]   comp;
  logic                      all_zero, top_set;

  assign axis     = k[2:1];
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    unique case (axis)
      2'd0:    begin s_dp1 = dp1[0]; s_dp2 = dp2[0]; end
      2'd1:    begin s_dp1 = dp1[1]; s_dp2 = dp2[1]; end
      default: begin s_dp1 = dp1[2]; s_dp2 = dp2[2]; end
    endcase
    unique case (mi)
      2'd0:    begin s_m = m[0]; s_vec = nv ? bin[0] : tin[0]; end
      2'd1:    begin s_m = m[1]; s_vec = nv ? bin[1] : tin[1]; end
      default: begin s_m = m[2]; s_vec = nv ? bin[2] : tin[2]; end
    endcase
  end

  always_comb begin
    mac_cmd.start = (state == ST_MAC);
    mac_cmd.clr   = (mi == 2'd0);
    mac_cmd.neg   = (mi != 2'd0) && !in_norm;
    if (!cx_ok) begin
      mac_a = (mi == 2'd0) ? OP_W'(du1) : OP_W'(dv1);
      mac_b = (mi == 2'd0) ? OP_W'(dv2) : OP_W'(du2);
    end else if (!in_norm) begin
      if (!k[0]) begin
        mac_a = (mi == 2'd0) ? OP_W'(dv1)   : OP_W'(s_dp1);
        mac_b = (mi == 2'd0) ? OP_W'(s_dp2) : OP_W'(dv2);
      end else begin
        mac_a = (mi == 2'd0) ? OP_W'(s_dp1) : OP_W'(du1);
        mac_b = (mi == 2'd0) ? OP_W'(du2)   : OP_W'(s_dp2);
      end
    end else begin
      mac_a = OP_W'($signed({1'b0, s_m}));
      mac_b = OP_W'($signed({1'b0, s_m}));
    end
  end

  assign num     = acc[PW-1:0];
  assign num_mag = num[PW-1] ? PW'(-num) : PW'(num);
  assign nsum    = NS_W'({s_m, {FRAC_SH{1'b0}}}) + NS_W'(len);

  always_comb begin
    div_start = (state == ST_DIV) || (state == ST_NDIV);
    if (state == ST_DIV) begin
      div_rem0  = DEN_W'(num_mag >> FRAC_SH);
      div_seq   = {num_mag[FRAC_SH-1:0], {ZPAD_W{1'b0}}};
      div_steps = DIV_CNT_W'(Q_W);
      div_den   = cx_mag;
    end else begin
      div_rem0  = DEN_W'(nsum[NS_W-1:FRAC_SH]);
      div_seq   = {nsum[FRAC_SH-1:0], {ZPAD_W{1'b0}}};
      div_steps = DIV_CNT_W'(FRAC_SH);
      div_den   = DEN_W'({len, 1'b0});
    end
  end

  always_comb begin
    qv       = div_sat ? SLOPE_SAT : SLOPE_W'(div_quot);
    slope    = div_neg ? -$signed(qv) : (div_sat ? SLOPE_MAX : $signed(qv));
    slope_st = k[0] ? -slope : slope;
    qn       = div_quot[FRAC_SH-1:0];
    qc       = ($signed({1'b0, qn}) > ONE_Q14) ? ONE_Q14 : OUT_W'(qn);
    comp     = s_vec[SLOPE_W-1] ? -$signed(qc) : $signed(qc);
    all_zero = (m[0] == '0) && (m[1] == '0) && (m[2] == '0);
    top_set  = (|m[0][MAG_W-1:MAG_W-2]) || (|m[1][MAG_W-1:MAG_W-2])
            || (|m[2][MAG_W-1:MAG_W-2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= '0;
      out_valid <= 1'b0;
      cx_ok     <= 1'b0;
      in_norm   <= 1'b0;
      nv        <= 1'b0;
      mi        <= '0;
      k         <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (phase < 2'd2) begin
              sv_px[phase[0]] <= pos_x[COORD_WIDTH-1:0];
              sv_py[phase[0]] <= pos_y[COORD_WIDTH-1:0];
              sv_pz[phase[0]] <= pos_z[COORD_WIDTH-1:0];
              sv_u[phase[0]]  <= tex_u[COORD_WIDTH-1:0];
              sv_v[phase[0]]  <= tex_v[COORD_WIDTH-1:0];
              phase <= phase + 2'd1;
            end else begin
              phase   <= '0;
              du1     <= sx(sv_u[1]) - sx(sv_u[0]);
              dv1     <= sx(sv_v[1]) - sx(sv_v[0]);
              du2     <= sx(tex_u[COORD_WIDTH-1:0]) - sx(sv_u[1]);
              dv2     <= sx(tex_v[COORD_WIDTH-1:0]) - sx(sv_v[1]);
              dp1[0]  <= sx(sv_px[1]) - sx(sv_px[0]);
              dp1[1]  <= sx(sv_py[1]) - sx(sv_py[0]);
              dp1[2]  <= sx(sv_pz[1]) - sx(sv_pz[0]);
              dp2[0]  <= sx(pos_x[COORD_WIDTH-1:0]) - sx(sv_px[1]);
              dp2[1]  <= sx(pos_y[COORD_WIDTH-1:0]) - sx(sv_py[1]);
              dp2[2]  <= sx(pos_z[COORD_WIDTH-1:0]) - sx(sv_pz[1]);
              cx_ok   <= 1'b0;
              in_norm <= 1'b0;
              mi      <= '0;
              res_deg <= 1'b0;
              state   <= ST_MAC;
            end
          end
        end
        ST_MAC: state <= ST_MACW;
        ST_MACW: begin
          if (mac_done) begin
            if (!cx_ok) begin
              if (mi == 2'd0) begin
                mi    <= 2'd1;
                state <= ST_MAC;
              end else begin
                cx_reg <= num;
                cx_mag <= num_mag;
                if (acc == '0) begin
                  res_t[0] <= '0;
                  res_t[1] <= ONE_Q14;
                  res_t[2] <= '0;
                  res_b[0] <= ONE_Q14;
                  res_b[1] <= '0;
                  res_b[2] <= '0;
                  res_deg  <= 1'b1;
                  state    <= ST_DONE;
                end else begin
                  cx_ok <= 1'b1;
                  k     <= '0;
                  mi    <= '0;
                  state <= ST_MAC;
                end
              end
            end else if (!in_norm) begin
              if (mi == 2'd0) begin
                mi    <= 2'd1;
                state <= ST_MAC;
              end else begin
                state <= ST_DIV;
              end
            end else begin
              if (mi == 2'd2) begin
                state <= ST_SQRT;
              end else begin
                mi    <= mi + 2'd1;
                state <= ST_MAC;
              end
            end
          end
        end
        ST_DIV: begin
          div_sat <= (num_mag >> FRAC_SH) >= cx_mag;
          div_neg <= (num[PW-1] == cx_reg[PW-1]);
          state   <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_done) begin
            unique case ({axis, k[0]})
              3'b000:  tin[0] <= slope_st;
              3'b001:  bin[0] <= slope_st;
              3'b010:  tin[1] <= slope_st;
              3'b011:  bin[1] <= slope_st;
              3'b100:  tin[2] <= slope_st;
              default: bin[2] <= slope_st;
            endcase
            if (k == 3'd5) begin
              nv    <= 1'b0;
              state <= ST_LOAD;
            end else begin
              k     <= k + 3'd1;
              mi    <= '0;
              state <= ST_MAC;
            end
          end
        end
        ST_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            if (nv) begin
              m[i] <= bin[i][SLOPE_W-1] ? MAG_W'(-bin[i]) : MAG_W'(bin[i]);
            end else begin
              m[i] <= tin[i][SLOPE_W-1] ? MAG_W'(-tin[i]) : MAG_W'(tin[i]);
            end
          end
          in_norm <= 1'b0;
          state   <= ST_SHIFT;
        end
        ST_SHIFT: begin
          if (all_zero) begin
            for (int i = 0; i < 3; i++) begin
              if (nv) begin
                res_b[i] <= '0;
              end else begin
                res_t[i] <= '0;
              end
            end
            if (nv) begin
              state <= ST_DONE;
            end else begin
              nv    <= 1'b1;
              state <= ST_LOAD;
            end
          end else if (!top_set) begin
            for (int i = 0; i < 3; i++) begin
              m[i] <= m[i] << 1;
            end
          end else begin
            in_norm <= 1'b1;
            mi      <= '0;
            state   <= ST_MAC;
          end
        end
        ST_SQRT: state <= ST_SQRTW;
        ST_SQRTW: begin
          if (sqrt_done) begin
            len   <= root;
            mi    <= '0;
            state <= ST_NDIV;
          end
        end
        ST_NDIV: state <= ST_NDIVW;
        ST_NDIVW: begin
          if (div_done) begin
            unique case ({nv, mi})
              3'b000:  res_t[0] <= comp;
              3'b001:  res_t[1] <= comp;
              3'b010:  res_t[2] <= comp;
              3'b100:  res_b[0] <= comp;
              3'b101:  res_b[1] <= comp;
              default: res_b[2] <= comp;
            endcase
            if (mi == 2'd2) begin
              if (nv) begin
                state <= ST_DONE;
              end else begin
                nv    <= 1'b1;
                state <= ST_LOAD;
              end
            end else begin
              mi    <= mi + 2'd1;
              state <= ST_NDIV;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid) begin
            tangent_x  <= res_t[0];
            tangent_y  <= res_t[1];
            tangent_z  <= res_t[2];
            binormal_x <= res_b[0];
            binormal_y <= res_b[1];
            binormal_z <= res_b[2];
            degenerate <= res_deg;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  tbn_mac #(.OP_W(OP_W), .ACC_W(ACC_W)) u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mac_cmd),
    .a    (mac_a),
    .b    (mac_b),
    .busy (mac_busy),
    .done (mac_done),
    .acc  (acc)
  );

  tbn_div #(.DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .rem0  (div_rem0),
    .seq   (div_seq),
    .steps (div_steps),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  tbn_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_SQRT),
    .x     (acc[SUM_W-1:0]),
    .busy  (sqrt_busy),
    .done  (sqrt_done),
    .root  (root)
  );

  `ASSERT_NEXT(a_out_from_done, !out_valid && state != ST_DONE, !out_valid)
  `ASSERT_IMPLIES(a_deg, out_valid && degenerate, tangent_y == ONE_Q14 && tangent_x == '0)
  `ASSERT_IMPLIES(a_ready_units_idle, in_ready, !mac_busy && !div_busy && !sqrt_busy)
  `ASSERT_IMPLIES(a_phase_range, 1'b1, phase != 2'd3)

endmodule

// ===== bench/triangle_tangent_binormal_unit_tb.sv =====
// Self-checking testbench for triangle_tangent_binormal_unit.
// Streams vertices, predicts each triangle's tangent/binormal and checks results;
// depends on tbn_pkg and the RTL only.
`timescale 1ns / 1ps

module triangle_tangent_binormal_unit_tb;
  import tbn_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef logic [IN_W-1:0] coord_t;

  typedef struct {
    logic signed [OUT_W-1:0] tangent[3];
    logic signed [OUT_W-1:0] binormal[3];
    logic                    degenerate;
  } frame_t;

  localparam int STALL_LIMIT = 50000;
  localparam int DRAIN_CYCLES = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t pos_x = '0, pos_y = '0, pos_z = '0, tex_u = '0, tex_v = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] tangent_x, tangent_y, tangent_z;
  logic signed [OUT_W-1:0] binormal_x, binormal_y, binormal_z;
  logic degenerate;

  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  frame_t frame_queue[$];

  // predictor state
  int unsigned corner_count = 0;
  coord_t kept[2][5];

  triangle_tangent_binormal_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_u(tex_u), .tex_v(tex_v),
    .out_valid(out_valid), .out_ready(out_ready),
    .tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
    .binormal_x(binormal_x), .binormal_y(binormal_y), .binormal_z(binormal_z),
    .degenerate(degenerate)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic wide_t widen(longint v);
    return wide_t'(v);
  endfunction

  function automatic longint slope_q16(wide_t num, wide_t den);
    logic [127:0] mn, md, q;
    logic neg;
    neg = (num[127] == den[127]);
    mn = (num[127] ? -num : num) << 16;
    md = den[127] ? -den : den;
    q = mn / md;
    if (q >= 128'h8000_0000) q = 128'h8000_0000;
    if (neg) return -longint'(q[63:0]);
    return (q > 128'h7FFF_FFFF) ? longint'(32'h7FFF_FFFF) : longint'(q[63:0]);
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void unit_q14(input longint c[3], output logic signed [OUT_W-1:0] o[3]);
    logic [63:0] m[3], big, sum, len, q;
    int s;
    big = 0;
    sum = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (c[i] < 0) ? -c[i] : c[i];
      if (m[i] > big) big = m[i];
    end
    if (big == 0) begin
      for (int i = 0; i < 3; i++) o[i] = '0;
      return;
    end
    while ((big << s) < (64'h1 << 30)) s++;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] << s;
      sum += m[i] * m[i];
    end
    len = floor_root(sum);
    for (int i = 0; i < 3; i++) begin
      q = (2 * m[i] * 16384 + len) / (2 * len);
      if (q > 16384) q = 16384;
      o[i] = (c[i] < 0) ? -q[OUT_W-1:0] : q[OUT_W-1:0];
    end
  endfunction

  // Takes one vertex; returns 1 with the triangle's frame on every third.
  function automatic bit frame_from_vertex(input coord_t vtx[5], output frame_t f);
    longint p[3][3], tu[3], tv[3], du1, dv1, du2, dv2, dp1, dp2, tin[3], bin[3];
    wide_t cx, cy, cz;
    if (corner_count < 2) begin
      kept[corner_count] = vtx;
      corner_count++;
      return 0;
    end
    corner_count = 0;
    for (int k = 0; k < 3; k++) begin
      for (int a = 0; a < 3; a++)
        p[a][k] = (k < 2) ? longint'($signed(kept[k][a])) : longint'($signed(vtx[a]));
      tu[k] = (k < 2) ? longint'($signed(kept[k][3])) : longint'($signed(vtx[3]));
      tv[k] = (k < 2) ? longint'($signed(kept[k][4])) : longint'($signed(vtx[4]));
    end
    du1 = tu[1] - tu[0];
    dv1 = tv[1] - tv[0];
    du2 = tu[2] - tu[1];
    dv2 = tv[2] - tv[1];
    cx = widen(du1) * widen(dv2) - widen(dv1) * widen(du2);
    f.degenerate = (cx == 0);
    if (f.degenerate) begin
      f.tangent = '{16'sd0, ONE_Q14, 16'sd0};
      f.binormal = '{ONE_Q14, 16'sd0, 16'sd0};
      return 1;
    end
    for (int a = 0; a < 3; a++) begin
      dp1 = p[a][1] - p[a][0];
      dp2 = p[a][2] - p[a][1];
      cy = widen(dv1) * widen(dp2) - widen(dp1) * widen(dv2);
      cz = widen(dp1) * widen(du2) - widen(du1) * widen(dp2);
      tin[a] = slope_q16(cy, cx);
      bin[a] = -slope_q16(cz, cx);
    end
    unit_q14(tin, f.tangent);
    unit_q14(bin, f.binormal);
    return 1;
  endfunction

  task automatic send_vertex(coord_t px, coord_t py, coord_t pz, coord_t u, coord_t v);
    coord_t vtx[5];
    frame_t f;
    int gap;
    vtx = '{px, py, pz, u, v};
    pos_x <= px;
    pos_y <= py;
    pos_z <= pz;
    tex_u <= u;
    tex_v <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (frame_from_vertex(vtx, f)) frame_queue.push_back(f);
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_triangle(coord_t c[3][5]);
    for (int k = 0; k < 3; k++) send_vertex(c[k][0], c[k][1], c[k][2], c[k][3], c[k][4]);
  endtask

  function automatic coord_t rand_coord(int kind);
    case (kind)
      0: return $urandom;
      1: return $urandom_range(0, 1 << 21) - (1 << 20);
      2: return ($urandom_range(0, 16) - 8) << 16;
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  task automatic test_extremes();
    send_triangle('{3{'{5{32'h7FFF_FFFF}}}});
    send_triangle('{3{'{5{32'h8000_0000}}}});
    send_triangle('{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000},
                    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
                    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF}});
  endtask

  task automatic test_degenerate_uv();
    send_triangle('{'{32'h0001_0000, 32'h0, 32'h0, 32'h0002_0000, 32'h0003_0000},
                    '{32'h0, 32'h0001_0000, 32'h0, 32'h0004_0000, 32'h0006_0000},
                    '{32'h0, 32'h0, 32'h0001_0000, 32'h0006_0000, 32'h0009_0000}});
  endtask

  task automatic test_zero_slope();
    send_triangle('{'{32'h5, 32'h5, 32'h5, 32'h0, 32'h0},
                    '{32'h5, 32'h5, 32'h5, 32'h0001_0000, 32'h0},
                    '{32'h5, 32'h5, 32'h5, 32'h0, 32'h0001_0000}});
  endtask

  task automatic test_saturation();
    send_triangle('{'{32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0},
                    '{32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h1, 32'h0},
                    '{32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h1, 32'h1}});
  endtask

  task automatic test_plain_triangle();
    send_triangle('{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
                    '{32'h0001_0000, 32'h0, 32'h0, 32'h0000_8000, 32'h0},
                    '{32'h0, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0000_8000}});
  endtask

  task automatic test_random_traffic(int triangles, int idle_pct, int stall_pct);
    coord_t c[3][5];
    int kind, shape;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int t = 0; t < triangles; t++) begin
      kind = $urandom_range(0, 3);
      shape = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++)
        for (int f = 0; f < 5; f++)
          c[k][f] = rand_coord((f < 3 && kind == 3) ? $urandom_range(0, 3) : kind);
      if (shape == 0) begin
        c[1][3] = c[0][3];
        c[1][4] = c[0][4];
      end else if (shape == 1) begin
        for (int a = 0; a < 3; a++) begin
          c[1][a] = c[0][a];
          c[2][a] = c[0][a];
        end
      end
      send_triangle(c);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    frame_t e;
    if (!rst && out_valid && out_ready) begin
      if (frame_queue.size() == 0) begin
        $error("unexpected result transfer");
        fail_count++;
      end else begin
        e = frame_queue.pop_front();
        check_field("tangent_x", e.tangent[0], tangent_x);
        check_field("tangent_y", e.tangent[1], tangent_y);
        check_field("tangent_z", e.tangent[2], tangent_z);
        check_field("binormal_x", e.binormal[0], binormal_x);
        check_field("binormal_y", e.binormal[1], binormal_y);
        check_field("binormal_z", e.binormal[2], binormal_z);
        check_field("degenerate", e.degenerate, degenerate);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_degenerate_uv();
    test_zero_slope();
    test_saturation();
    test_plain_triangle();
    test_random_traffic(100, 0, 0);
    test_random_traffic(100, 79, 0);
    test_random_traffic(100, 0, 79);
    test_random_traffic(100, 26, 26);
    in_valid <= 1'b0;
    while (frame_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
